// File: sv/bgr_pkg.sv
`default_nettype none

package bgr_pkg;

  // Default sizing
  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned GLYPH_SIZE_DEF    = 32;
  localparam int unsigned MAX_POSITION_DEF  = 127;

  // Fixed glyph store layout: 256 glyphs of 32 rows by 4 bytes
  localparam int unsigned GLYPH_COUNT  = 256;
  localparam int unsigned ROW_BYTES    = 4;
  localparam int unsigned ROWS_MAX     = 32;
  localparam int unsigned ROW_W        = $clog2(ROWS_MAX);
  localparam int unsigned GLYPH_NUM_W  = $clog2(GLYPH_COUNT);
  localparam int unsigned LANE_DEPTH   = GLYPH_COUNT * ROWS_MAX;
  localparam int unsigned CHAR_PITCH_W = 5;   // 32 pixels per character

  // Field widths
  localparam int unsigned CODE_W = 16;
  localparam int unsigned X_W    = 14;
  localparam int unsigned Y_W    = 13;
  localparam int unsigned BASE_W = 12;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEN_COLOR = 2'd2;

  localparam logic [CFG_W-1:0] PEN_COLOR_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_CODE_WR  = 2'd0,
    CMD_GLYPH_WR = 2'd1,
    CMD_DRAW     = 2'd2,
    CMD_END      = 2'd3
  } cmd_e;

  // Built-in glyph drawn when a code has no table entry
  localparam logic [31:0] FALLBACK_ROWS [ROWS_MAX] = '{
    32'h00C1C000, 32'h01C3C000, 32'h01E3C000, 32'h01E7E000,
    32'h01FFE000, 32'h01FFE000, 32'h03FFE000, 32'h03FFE000,
    32'h07FFE000, 32'h1FFFF03C, 32'h3FFFF03E, 32'h7FFFF00E,
    32'hFFFFF007, 32'h3FFFE007, 32'h1FFFE007, 32'h07FFC00E,
    32'h03FF9F3E, 32'h00FFFFFC, 32'h00FFFFF8, 32'h00FFFFE0,
    32'h00FFFFE0, 32'h00FFFFE0, 32'h00FFFFE0, 32'h00FFFFE0,
    32'h007FFFC0, 32'h007FFFC0, 32'h003FFFC0, 32'h003F0FC0,
    32'h003F0FC0, 32'h003F0FC0, 32'h003F0FC0, 32'h007F0FC0
  };

  // Requests to the code table
  typedef struct packed {
    logic              wr;
    logic [7:0]        entry;
    logic [CODE_W-1:0] code;
    logic              start;
  } scan_req_t;

  typedef struct packed {
    logic                   ready;
    logic                   done;
    logic                   found;
    logic [GLYPH_NUM_W-1:0] glyph;
  } scan_rsp_t;

  // Requests to the glyph row engine
  typedef struct packed {
    logic                   wr;
    logic [7:0]             entry;
    logic [6:0]             offset;
    logic [7:0]             data;
    logic                   start;
    logic                   found;
    logic [GLYPH_NUM_W-1:0] glyph;
    logic [X_W-1:0]         x;
    logic [Y_W-1:0]         y0;
  } row_req_t;

endpackage

`default_nettype wire

// File: sv/bgr_in_if.sv
`default_nettype none

interface bgr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  entry;
  logic [6:0]  byte_offset;
  logic [7:0]  glyph_byte;
  logic [15:0] char_code;

  modport source (
    output valid, command, entry, byte_offset, glyph_byte, char_code,
    input  ready
  );
  modport sink (
    input  valid, command, entry, byte_offset, glyph_byte, char_code,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/bgr_out_if.sv
`default_nettype none

interface bgr_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        row_mask;
  logic signed [13:0] row_x;
  logic signed [12:0] row_y;
  logic               glyph_found;
  logic               last_row;

  modport source (
    output valid, row_mask, row_x, row_y, glyph_found, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_mask, row_x, row_y, glyph_found, last_row,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/bgr_ram.sv
`default_nettype none

module bgr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/bgr_scan.sv
`default_nettype none

module bgr_scan
  import bgr_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire scan_req_t req_i,
  output scan_rsp_t      rsp_o
);

  localparam int unsigned TW = $clog2(TABLE_ENTRIES);
  localparam logic [TW-1:0] LAST_ENTRY = TW'(TABLE_ENTRIES - 1);
  localparam logic [TW:0]   ENTRY_CNT  = (TW+1)'(TABLE_ENTRIES);

  logic              clearing_q, clearing_d;
  logic [TW-1:0]     clr_addr_q, clr_addr_d;
  logic              scanning_q, scanning_d;
  logic [TW:0]       idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [TW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [CODE_W-1:0] code_q, code_d;

  logic              ram_we;
  logic [TW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [CODE_W-1:0] ram_rdata;
  logic              in_range;
  logic              hit, empty, stop;

  bgr_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[TW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Write port: clearing pass after reset, then code loads
  always_comb begin
    in_range  = 32'(req_i.entry) < 32'(TABLE_ENTRIES);
    ram_we    = clearing_q | (req_i.wr & in_range);
    ram_waddr = clearing_q ? clr_addr_q : TW'(req_i.entry);
    ram_wdata = clearing_q ? '0 : req_i.code;
  end

  // Compare the entry read last cycle; a hit, an empty entry or the last entry ends the search
  always_comb begin
    empty = ram_rdata == '0;
    hit   = !empty && (ram_rdata == code_q);
    stop  = scanning_q && pend_q && (empty || hit || (cmp_idx_q == LAST_ENTRY));
  end

  always_comb begin
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    scanning_d = scanning_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    code_d     = code_q;
    ram_re     = 1'b0;

    if (clearing_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LAST_ENTRY) begin
        clearing_d = 1'b0;
      end
    end

    if (req_i.start) begin
      scanning_d = 1'b1;
      idx_d      = '0;
      code_d     = req_i.code;
    end else if (stop) begin
      scanning_d = 1'b0;
    end else if (scanning_q && (idx_q < ENTRY_CNT)) begin
      // one read per cycle, compared in the cycle after
      ram_re    = 1'b1;
      pend_d    = 1'b1;
      cmp_idx_d = idx_q[TW-1:0];
      idx_d     = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      scanning_q <= 1'b0;
      idx_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
      scanning_q <= scanning_d;
      idx_q      <= idx_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    code_q    <= code_d;
  end

  assign rsp_o.ready = !clearing_q && !scanning_q;
  assign rsp_o.done  = stop;
  assign rsp_o.found = hit;
  assign rsp_o.glyph = GLYPH_NUM_W'(cmp_idx_q);

`ifndef NO_ASSERTIONS
  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scanning_q |-> !req_i.wr && !req_i.start)
    else $error("table request during a search");
  a_clear_before_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !scanning_q && !req_i.start)
    else $error("search started before table clear finished");
  a_done_ends_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop |=> !scanning_q)
    else $error("search still running after completion");
`endif

endmodule

`default_nettype wire

// File: sv/bgr_rows.sv
`default_nettype none

module bgr_rows
  import bgr_pkg::*;
#(
  parameter int unsigned GLYPH_SIZE = GLYPH_SIZE_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire row_req_t req_i,
  output logic          busy_o,
  bgr_out_if.source     out_o
);

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_SIZE - 1);
  localparam int unsigned LANE_AW = $clog2(LANE_DEPTH);

  logic                   active_q, active_d;
  logic                   found_q;
  logic [GLYPH_NUM_W-1:0] glyph_q;
  logic [X_W-1:0]         x_q;
  logic [Y_W-1:0]         y0_q;
  logic [ROW_W-1:0]       iss_row_q, iss_row_d;
  logic                   pend_q, pend_d;
  logic [ROW_W-1:0]       pend_row_q;

  logic                   ov_q, ov_d;
  logic [31:0]            mask_q;
  logic [X_W-1:0]         rx_q;
  logic [Y_W-1:0]         ry_q;
  logic                   fnd_q;
  logic                   last_q;

  logic                   out_free, load, issue;
  logic [LANE_AW-1:0]     waddr, raddr;
  logic [31:0]            ram_row;

  // Four byte lanes, one row of a glyph per address
  assign waddr = {req_i.entry, req_i.offset[6:2]};
  assign raddr = {glyph_q, iss_row_q};

  for (genvar l = 0; l < ROW_BYTES; l++) begin : g_lane
    bgr_ram #(
      .WIDTH (8),
      .DEPTH (LANE_DEPTH)
    ) u_lane (
      .clk_i   (clk_i),
      .we_i    (req_i.wr && (req_i.offset[1:0] == 2'(l))),
      .waddr_i (waddr),
      .wdata_i (req_i.data),
      .re_i    (issue && found_q),
      .raddr_i (raddr),
      .rdata_o (ram_row[31-8*l -: 8])
    );
  end

  // Read one row ahead; read data holds until the output slot frees up
  always_comb begin
    out_free  = !ov_q || out_o.ready;
    load      = pend_q && out_free;
    issue     = active_q && (!pend_q || load);
    active_d  = active_q;
    iss_row_d = iss_row_q;
    pend_d    = pend_q;
    ov_d      = ov_q;

    if (req_i.start) begin
      active_d  = 1'b1;
      iss_row_d = '0;
    end else if (issue) begin
      iss_row_d = iss_row_q + 1'b1;
      if (iss_row_q == LAST_ROW) begin
        active_d = 1'b0;
      end
    end

    if (issue) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end

    if (load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      iss_row_q <= '0;
      pend_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      active_q  <= active_d;
      iss_row_q <= iss_row_d;
      pend_q    <= pend_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      found_q <= req_i.found;
      glyph_q <= req_i.glyph;
      x_q     <= req_i.x;
      y0_q    <= req_i.y0;
    end
    if (issue) begin
      pend_row_q <= iss_row_q;
    end
    if (load) begin
      mask_q <= found_q ? ram_row : FALLBACK_ROWS[pend_row_q];
      rx_q   <= x_q;
      ry_q   <= y0_q + Y_W'(pend_row_q);
      fnd_q  <= found_q;
      last_q <= pend_row_q == LAST_ROW;
    end
  end

  assign busy_o            = active_q || pend_q;
  assign out_o.valid       = ov_q;
  assign out_o.row_mask    = mask_q;
  assign out_o.row_x       = rx_q;
  assign out_o.row_y       = ry_q;
  assign out_o.glyph_found = fnd_q;
  assign out_o.last_row    = last_q;

`ifndef NO_ASSERTIONS
  a_start_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_o)
    else $error("row engine started while busy");
  a_last_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (pend_row_q == LAST_ROW)) |=> !busy_o)
    else $error("rows left after the final row");
  a_no_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !req_i.wr)
    else $error("glyph write during row output");
`endif

endmodule

`default_nettype wire

// File: sv/bitmap_glyph_row_generator.sv
`default_nettype none

// Text character generator. Commands arrive one transaction at a time:
// code-table writes, glyph byte writes and end-of-text produce nothing. A
// draw searches the code table from entry 0, one entry per cycle out of the
// table memory, stopping at the first match, the first empty entry or the
// last entry, then streams GLYPH_SIZE row transactions, one per cycle while
// the sink keeps ready high. With ready held high, the only variable part of a
// draw is the table search, which examines from 1 to TABLE_ENTRIES entries.
// The last row may still wait in the output register while the next command
// is taken.
// After reset the code table is cleared by a pass over all TABLE_ENTRIES
// entries, during which no command is accepted; configuration writes are
// taken at any time but must only change while the block is idle.
module bitmap_glyph_row_generator
  import bgr_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned GLYPH_SIZE    = GLYPH_SIZE_DEF,
  parameter int unsigned MAX_POSITION  = MAX_POSITION_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  bgr_in_if.sink                    in_i,
  bgr_out_if.source                 out_o
);

  localparam int unsigned PW = $clog2(MAX_POSITION + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_POSITION);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ROWS = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [X_W-1:0]    x_q, x_d;
  logic [BASE_W-1:0] base_x_q, base_y_q;
  logic [CFG_W-1:0]  pen_color_q;

  scan_req_t scan_req;
  scan_rsp_t scan_rsp;
  row_req_t  row_req;
  logic      row_busy;
  logic      accept;
  cmd_e      cmd;

  assign cmd         = cmd_e'(in_i.command);
  assign in_i.ready  = (state_q == ST_IDLE) && scan_rsp.ready;
  assign accept      = in_i.valid && in_i.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q    <= '0;
      base_y_q    <= '0;
      pen_color_q <= PEN_COLOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_X:    base_x_q    <= cfg_data_i[BASE_W-1:0];
        CFG_BASE_Y:    base_y_q    <= cfg_data_i[BASE_W-1:0];
        CFG_PEN_COLOR: pen_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Command sequencing and character position
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    x_d     = x_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_DRAW: begin
              state_d = ST_SCAN;
              x_d     = {{(X_W-BASE_W){base_x_q[BASE_W-1]}}, base_x_q}
                        + X_W'({pos_q, {CHAR_PITCH_W{1'b0}}});
              pos_d   = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
            end
            CMD_END: pos_d = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          state_d = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (!row_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  always_comb begin
    scan_req.wr    = accept && (cmd == CMD_CODE_WR);
    scan_req.entry = in_i.entry;
    scan_req.code  = in_i.char_code;
    scan_req.start = accept && (cmd == CMD_DRAW);

    row_req.wr     = accept && (cmd == CMD_GLYPH_WR);
    row_req.entry  = in_i.entry;
    row_req.offset = in_i.byte_offset;
    row_req.data   = in_i.glyph_byte;
    row_req.start  = (state_q == ST_SCAN) && scan_rsp.done;
    row_req.found  = scan_rsp.found;
    row_req.glyph  = scan_rsp.glyph;
    row_req.x      = x_q;
    row_req.y0     = {base_y_q[BASE_W-1], base_y_q};
  end

  bgr_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .rsp_o  (scan_rsp)
  );

  bgr_rows #(
    .GLYPH_SIZE (GLYPH_SIZE)
  ) u_rows (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (row_req),
    .busy_o (row_busy),
    .out_o  (out_o)
  );

`ifndef NO_ASSERTIONS
  a_draw_moves_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd == CMD_DRAW)) |=> (pos_q != '0))
    else $error("position did not advance after a draw");
  a_end_clears_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd == CMD_END)) |=> (pos_q == '0))
    else $error("position not cleared by end command");
  a_rows_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROWS) |-> !scan_rsp.done)
    else $error("search result while rows are streaming");
`endif

endmodule

`default_nettype wire

// File: sim/bitmap_glyph_row_generator_tb.sv
module bitmap_glyph_row_generator_tb;
  import bgr_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int NUM_ROWS    = GLYPH_SIZE_DEF;
  localparam int GLYPH_BYTES = ROW_BYTES * NUM_ROWS;

  // Glyph drawn when a code has no table entry, one word per row
  localparam logic [31:0] MISSING_GLYPH [32] = '{
    32'h00C1C000, 32'h01C3C000, 32'h01E3C000, 32'h01E7E000,
    32'h01FFE000, 32'h01FFE000, 32'h03FFE000, 32'h03FFE000,
    32'h07FFE000, 32'h1FFFF03C, 32'h3FFFF03E, 32'h7FFFF00E,
    32'hFFFFF007, 32'h3FFFE007, 32'h1FFFE007, 32'h07FFC00E,
    32'h03FF9F3E, 32'h00FFFFFC, 32'h00FFFFF8, 32'h00FFFFE0,
    32'h00FFFFE0, 32'h00FFFFE0, 32'h00FFFFE0, 32'h00FFFFE0,
    32'h007FFFC0, 32'h007FFFC0, 32'h003FFFC0, 32'h003F0FC0,
    32'h003F0FC0, 32'h003F0FC0, 32'h003F0FC0, 32'h007F0FC0
  };

  // Glyphs that get fully loaded, so draws may hit them
  localparam logic [7:0] LOADED_GLYPHS [4] = '{8'd0, 8'd1, 8'd2, 8'd255};

  typedef logic [CODE_W-1:0] code_tbl_t [TABLE_ENTRIES_DEF];

  typedef struct packed {
    cmd_e              cmd;
    logic [7:0]        entry;
    logic [6:0]        offset;
    logic [7:0]        data;
    logic [CODE_W-1:0] code;
    logic              hold;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0]    mask;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           found;
    logic           last_row;
  } glyph_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bgr_in_if  cmd_if ();
  bgr_out_if row_if ();

  bitmap_glyph_row_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cmd_if),
    .out_o      (row_if)
  );

  always #2 clk_i = ~clk_i;

  // Predicted block state
  code_tbl_t         code_mem;
  logic [7:0]        glyph_mem [GLYPH_COUNT * GLYPH_BYTES];
  logic [6:0]        char_pos;
  logic [BASE_W-1:0] base_x_q;
  logic [BASE_W-1:0] base_y_q;
  logic [CFG_W-1:0]  pen_color_q;

  // Stimulus planning: table contents and loaded glyph bytes as queued
  code_tbl_t              plan_code;
  bit [GLYPH_BYTES-1:0]   plan_bytes [GLYPH_COUNT];

  cmd_item_t  cmd_backlog [$];
  glyph_row_t rows_due [$];
  cmd_item_t  cur_cmd;
  int         rows_in;
  int         rows_out;
  int         err_cnt;
  int         cycle_cnt;
  int         send_gap;
  int         stall_left;
  bit         idle_en;

  // First table entry holding the code; the scan ends at an empty entry
  function automatic int find_entry(input code_tbl_t tbl, input logic [CODE_W-1:0] code);
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      if (tbl[i] == '0) return -1;
      if (tbl[i] == code) return i;
    end
    return -1;
  endfunction

  // Update the predicted state for one accepted command; draws queue their rows
  function automatic void apply_command(input cmd_item_t c);
    int          hit;
    logic [7:0]  g;
    glyph_row_t  row;
    case (c.cmd)
      CMD_CODE_WR:  code_mem[c.entry] = c.code;
      CMD_GLYPH_WR: glyph_mem[{c.entry, c.offset}] = c.data;
      CMD_END:      char_pos = '0;
      default: begin
        hit = find_entry(code_mem, c.code);
        g   = hit[7:0];
        for (int r = 0; r < NUM_ROWS; r++) begin
          if (hit >= 0) begin
            row.mask = {glyph_mem[{g, 5'(r), 2'd0}], glyph_mem[{g, 5'(r), 2'd1}],
                        glyph_mem[{g, 5'(r), 2'd2}], glyph_mem[{g, 5'(r), 2'd3}]};
          end else begin
            row.mask = MISSING_GLYPH[r];
          end
          row.x        = {{2{base_x_q[BASE_W-1]}}, base_x_q} + {2'b00, char_pos, 5'b00000};
          row.y        = {base_y_q[BASE_W-1], base_y_q} + 13'(r);
          row.found    = (hit >= 0);
          row.last_row = (r == NUM_ROWS - 1);
          rows_due.push_back(row);
        end
        rows_in += NUM_ROWS;
        if (char_pos < 7'(MAX_POSITION_DEF)) char_pos++;
      end
    endcase
  endfunction

  // Queue a command; a draw that would hit a glyph not fully loaded draws code 0
  function automatic void push_cmd(input cmd_e c, input logic [7:0] e, input logic [6:0] o,
                                   input logic [7:0] d, input logic [CODE_W-1:0] code,
                                   input bit hold = 1'b0);
    cmd_item_t it;
    int        hit;
    if (c == CMD_DRAW) begin
      hit = find_entry(plan_code, code);
      if (hit >= 0 && !(&plan_bytes[hit])) code = '0;
    end
    if (c == CMD_CODE_WR) plan_code[e] = code;
    if (c == CMD_GLYPH_WR) plan_bytes[e][o] = 1'b1;
    it.cmd    = c;
    it.entry  = e;
    it.offset = o;
    it.data   = d;
    it.code   = code;
    it.hold   = hold;
    cmd_backlog.push_back(it);
  endfunction

  function automatic void push_draw(input logic [CODE_W-1:0] code, input bit hold = 1'b0);
    push_cmd(CMD_DRAW, 8'($urandom), 7'($urandom), 8'($urandom), code, hold);
  endfunction

  // Random mix, biased toward draws of codes that hit loaded glyphs
  function automatic void push_random(input int n);
    int                sel;
    int                pick;
    bit                hold;
    logic [7:0]        e;
    logic [CODE_W-1:0] code;
    for (int k = 0; k < n; k++) begin
      sel  = $urandom_range(0, 9);
      hold = ($urandom_range(0, 11) == 0);
      if (sel < 5) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) code = plan_code[LOADED_GLYPHS[$urandom_range(0, 3)]];
        else if (pick < 8) code = 16'($urandom);
        else code = '0;
        push_draw(code, hold);
      end else if (sel < 7) begin
        e    = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        code = ($urandom_range(0, 6) == 0) ? 16'h0000 : 16'($urandom);
        push_cmd(CMD_CODE_WR, e, 7'($urandom), 8'($urandom), code, hold);
      end else if (sel < 9) begin
        e = ($urandom_range(0, 3) == 0) ? 8'($urandom) : LOADED_GLYPHS[$urandom_range(0, 3)];
        push_cmd(CMD_GLYPH_WR, e, 7'($urandom), 8'($urandom), 16'($urandom), hold);
      end else begin
        push_cmd(CMD_END, 8'($urandom), 7'($urandom), 8'($urandom), 16'($urandom), hold);
      end
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BASE_X:    base_x_q = val[BASE_W-1:0];
      CFG_BASE_Y:    base_y_q = val[BASE_W-1:0];
      CFG_PEN_COLOR: pen_color_q = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [BASE_W-1:0] bx, input logic [BASE_W-1:0] by,
                            input logic [CFG_W-1:0] pen);
    write_reg(CFG_BASE_X, {4'h0, bx});
    write_reg(CFG_BASE_Y, {4'h0, by});
    write_reg(CFG_PEN_COLOR, pen);
    @(negedge clk_i);
  endtask

  // Wait until every command is taken and every row has arrived, then let the block settle
  task automatic settle(input int cycles);
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || cmd_if.valid || rows_out < rows_in);
    repeat (cycles) @(negedge clk_i);
  endtask

  // Command driver: one transaction at a time from the backlog, with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        apply_command(cur_cmd);
        if (idle_en && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_if.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].hold && rows_out < rows_in)) begin
          cur_cmd = cmd_backlog.pop_front();
          cmd_if.valid       <= 1'b1;
          cmd_if.command     <= cur_cmd.cmd;
          cmd_if.entry       <= cur_cmd.entry;
          cmd_if.byte_offset <= cur_cmd.offset;
          cmd_if.glyph_byte  <= cur_cmd.data;
          cmd_if.char_code   <= cur_cmd.code;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Row monitor: check each row transaction, stall ready in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      row_if.ready <= 1'b0;
    end else begin
      if (row_if.valid && row_if.ready) begin
        rows_out <= rows_out + 1;
        if (rows_due.size() == 0) begin
          $error("row transaction with nothing expected, mask 0x%0h", row_if.row_mask);
          err_cnt++;
        end else begin
          compare_field("row_mask", rows_due[0].mask, row_if.row_mask);
          compare_field("row_x", 32'(rows_due[0].x), 32'($unsigned(row_if.row_x)));
          compare_field("row_y", 32'(rows_due[0].y), 32'($unsigned(row_if.row_y)));
          compare_field("glyph_found", 32'(rows_due[0].found), 32'(row_if.glyph_found));
          compare_field("last_row", 32'(rows_due[0].last_row), 32'(row_if.last_row));
          void'(rows_due.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        row_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 11);
        row_if.ready <= 1'b0;
      end else begin
        row_if.ready <= 1'b1;
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [CODE_W-1:0] absent;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_BASE_X;
    cfg_data_i         = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.command     = CMD_END;
    cmd_if.entry       = '0;
    cmd_if.byte_offset = '0;
    cmd_if.glyph_byte  = '0;
    cmd_if.char_code   = '0;
    row_if.ready       = 1'b0;
    foreach (code_mem[i]) code_mem[i] = '0;
    foreach (plan_code[i]) plan_code[i] = '0;
    foreach (plan_bytes[i]) plan_bytes[i] = '0;
    foreach (glyph_mem[i]) glyph_mem[i] = '0;
    char_pos    = '0;
    base_x_q    = '0;
    base_y_q    = '0;
    pen_color_q = PEN_COLOR_RST;
    rows_in     = 0;
    rows_out    = 0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    send_gap    = 0;
    stall_left  = 0;
    idle_en     = 1'b1;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, loaded glyphs, hits, misses, code zero, end of text
    set_config(12'h000, 12'h000, 16'h0000);
    push_draw(16'h0000);
    push_draw(16'hBEEF);
    foreach (LOADED_GLYPHS[i]) begin
      for (int o = 0; o < GLYPH_BYTES; o++) begin
        push_cmd(CMD_GLYPH_WR, LOADED_GLYPHS[i], 7'(o),
                 (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 16'($urandom));
      end
    end
    push_cmd(CMD_CODE_WR, 8'd0, 7'd0, 8'd0, 16'hFFFF);
    push_cmd(CMD_CODE_WR, 8'd1, 7'd0, 8'd0, 16'h0001);
    push_cmd(CMD_CODE_WR, 8'd2, 7'd0, 8'd0, 16'h8000);
    push_draw(16'hFFFF);
    push_draw(16'h0001);
    push_draw(16'h8000);
    push_draw(16'h7777);
    push_draw(16'h0000);
    push_cmd(CMD_END, 8'hFF, 7'h7F, 8'hFF, 16'hFFFF);
    push_draw(16'h0001);
    push_cmd(CMD_GLYPH_WR, 8'd2, 7'd127, 8'hA5, 16'h0000);
    push_cmd(CMD_GLYPH_WR, 8'd2, 7'd0, 8'h5A, 16'h0000);
    push_draw(16'h8000);
    // emptying entry 1 cuts the scan short, so its code falls back
    push_cmd(CMD_CODE_WR, 8'd1, 7'd0, 8'd0, 16'h0000);
    push_draw(16'h0001);
    push_cmd(CMD_CODE_WR, 8'd1, 7'd0, 8'd0, 16'h0001);
    push_cmd(CMD_END, 8'd0, 7'd0, 8'd0, 16'h0000, 1'b1);
    push_draw(16'h8000);
    settle(8);

    // Run the position into saturation without an end command
    set_config(12'h800, 12'h7FF, 16'hFFFF);
    for (int k = 0; k < MAX_POSITION_DEF + 3; k++) begin
      push_draw((k % 3 == 0) ? 16'hFFFF : (k % 3 == 1) ? 16'h0001 : 16'h7777);
    end
    push_cmd(CMD_END, 8'd0, 7'd0, 8'd0, 16'h0000);
    push_draw(16'h0001);
    settle(8);

    // Full table: hit on the last entry, a miss over all entries, code zero
    set_config(12'h7FF, 12'h800, 16'h8001);
    for (int e = 3; e < TABLE_ENTRIES_DEF - 1; e++) begin
      push_cmd(CMD_CODE_WR, 8'(e), 7'($urandom), 8'($urandom), 16'($urandom_range(1, 65535)));
    end
    push_cmd(CMD_CODE_WR, 8'd255, 7'd0, 8'd0, 16'hCAFE);
    push_draw(16'hCAFE);
    do absent = 16'($urandom_range(1, 65535));
    while (find_entry(plan_code, absent) >= 0);
    push_draw(absent);
    push_draw(16'h0000);
    push_cmd(CMD_CODE_WR, 8'd3, 7'd0, 8'd0, 16'h0000);
    push_draw(16'hFFFF);
    settle(8);

    // Random traffic with idling on both sides
    set_config(12'($urandom), 12'($urandom), 16'($urandom));
    push_random(60);
    settle(8);

    // Last stretch runs without idling
    idle_en = 1'b0;
    set_config(12'($urandom), 12'($urandom), 16'($urandom));
    push_random(40);
    settle(40);

    if (rows_due.size() != 0) begin
      $error("%0d expected rows never arrived", rows_due.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
